// ----- hw/rtl/tcbs_pkg.sv -----
// Shared types and constants for the text console buffer with scroll.
package tcbs_pkg;

    localparam int ROWS_DEF = 4;
    localparam int COLS_DEF = 21;
    localparam int QDEPTH   = 4;
    localparam int QAW      = $clog2(QDEPTH);

    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam logic [2:0] MODE_WRITE = 3'd0;
    localparam logic [2:0] MODE_POKE  = 3'd1;
    localparam logic [2:0] MODE_CLEAR = 3'd2;
    localparam logic [2:0] MODE_READ  = 3'd3;
    localparam logic [2:0] MODE_FLUSH = 3'd4;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_WRITE,
        OP_NEWLINE,
        OP_POKE,
        OP_CLEAR,
        OP_READ,
        OP_FLUSH
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] ch;
        logic [4:0] col;
        logic [1:0] row;
        logic       in_grid;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_FILL,
        ST_LINE_END,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

// ----- hw/rtl/tcbs_front.sv -----
// Input side: accepts transfers and decodes them into queued commands.
module tcbs_front #(
    parameter int ROWS = tcbs_pkg::ROWS_DEF,
    parameter int COLS = tcbs_pkg::COLS_DEF
) (
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [15:0]         s_axis_tdata,  // char_code[7:0], column[12:8], row[14:13]
    input  logic [2:0]          s_axis_tuser,  // mode[2:0]
    input  tcbs_pkg::q_status_t q_stat,
    output logic                push,
    output tcbs_pkg::cmd_t      push_cmd
);

    logic [7:0] ch;
    logic [4:0] col;
    logic [1:0] row;

    assign ch  = s_axis_tdata[7:0];
    assign col = s_axis_tdata[12:8];
    assign row = s_axis_tdata[14:13];

    assign s_axis_tready = !q_stat.full;
    assign push          = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        push_cmd.ch      = ch;
        push_cmd.col     = col;
        push_cmd.row     = row;
        push_cmd.in_grid = (32'(row) < 32'(ROWS)) && (32'(col) < 32'(COLS));
        unique case (s_axis_tuser)
            tcbs_pkg::MODE_WRITE:
                push_cmd.op = (ch == tcbs_pkg::CHAR_NEWLINE) ? tcbs_pkg::OP_NEWLINE
                                                             : tcbs_pkg::OP_WRITE;
            tcbs_pkg::MODE_POKE:  push_cmd.op = tcbs_pkg::OP_POKE;
            tcbs_pkg::MODE_CLEAR: push_cmd.op = tcbs_pkg::OP_CLEAR;
            tcbs_pkg::MODE_READ:  push_cmd.op = tcbs_pkg::OP_READ;
            tcbs_pkg::MODE_FLUSH: push_cmd.op = tcbs_pkg::OP_FLUSH;
            default:              push_cmd.op = tcbs_pkg::OP_NOP;
        endcase
    end

endmodule

// ----- hw/rtl/tcbs_fifo.sv -----
// Command queue between the decode side and the grid engine.
module tcbs_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  tcbs_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output tcbs_pkg::cmd_t      head,
    output tcbs_pkg::q_status_t q_stat
);

    localparam int QAW = tcbs_pkg::QAW;
    localparam logic [QAW-1:0] PTR_LAST = QAW'(tcbs_pkg::QDEPTH - 1);
    localparam logic [QAW:0]   CNT_FULL = (QAW+1)'(tcbs_pkg::QDEPTH);

    tcbs_pkg::cmd_t  q_mem [tcbs_pkg::QDEPTH];
    logic [QAW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QAW:0]    count_reg, count_next;
    logic            do_push, do_pop;

    assign q_stat.full  = (count_reg == CNT_FULL);
    assign q_stat.empty = (count_reg == '0);
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + QAW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + QAW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + (QAW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - (QAW+1)'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hw/rtl/tcbs_engine.sv -----
// Grid engine: character store, cursor, scroll ring and result register.
module tcbs_engine #(
    parameter int ROWS = tcbs_pkg::ROWS_DEF,
    parameter int COLS = tcbs_pkg::COLS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tcbs_pkg::cmd_t      head,
    input  tcbs_pkg::q_status_t q_stat,
    output logic                pop,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [15:0]         m_axis_tdata  // cell_char[7:0], is_dirty[8],
                                              // cursor_row_out[10:9], cursor_col_out[15:11]
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int DEPTH = ROWS * COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);
    localparam logic [AW-1:0] COLS_A   = AW'(COLS);

    function automatic logic [RW-1:0] phys(input logic [RW-1:0] top,
                                           input logic [RW-1:0] vis);
        logic [RW:0] s;
        s = {1'b0, top} + {1'b0, vis};
        if (s >= (RW+1)'(ROWS))
        begin
            s = s - (RW+1)'(ROWS);
        end
        return s[RW-1:0];
    endfunction

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
        return AW'(AW'(r) * COLS_A + AW'(c));
    endfunction

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    tcbs_pkg::state_t state_reg, state_next;
    tcbs_pkg::cmd_t   cmd_reg, cmd_next;
    logic [RW-1:0]    cur_row_reg, cur_row_next;
    logic [CW-1:0]    cur_col_reg, cur_col_next;
    logic [RW-1:0]    top_reg, top_next;
    logic             dirty_reg, dirty_next;
    logic [ROWS-1:0]  row_valid_reg, row_valid_next;
    logic [RW-1:0]    row_sel_reg, row_sel_next;
    logic [CW-1:0]    fill_col_reg, fill_col_next;
    logic [7:0]       cell_reg, cell_next;
    logic             out_valid_reg, out_valid_next;
    logic [15:0]      out_data_reg, out_data_next;

    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_waddr, mem_raddr;
    logic [7:0]       mem_wdata;

    logic             addr_mode;
    logic [RW-1:0]    p_sel;
    logic [CW-1:0]    col_sel;
    logic             scroll;
    logic [RW-1:0]    adv_row, adv_top;
    logic             out_load;

    assign addr_mode = (cmd_reg.op == tcbs_pkg::OP_POKE) || (cmd_reg.op == tcbs_pkg::OP_READ);
    assign p_sel     = phys(top_reg, addr_mode ? RW'(cmd_reg.row) : cur_row_reg);
    assign col_sel   = addr_mode ? CW'(cmd_reg.col) : cur_col_reg;
    assign scroll    = (cur_row_reg == ROW_LAST);
    assign adv_row   = scroll ? ROW_LAST : cur_row_reg + RW'(1);
    assign adv_top   = !scroll ? top_reg : ((top_reg == ROW_LAST) ? '0 : top_reg + RW'(1));
    assign out_load  = (state_reg == tcbs_pkg::ST_DONE) && (!out_valid_reg || m_axis_tready);
    assign pop       = (state_reg == tcbs_pkg::ST_IDLE) && !q_stat.empty;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tcbs_pkg::ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = tcbs_pkg::ST_START;
                end
            end
            tcbs_pkg::ST_START:
            begin
                unique case (cmd_reg.op)
                    tcbs_pkg::OP_WRITE, tcbs_pkg::OP_POKE:
                    begin
                        if (cmd_reg.op == tcbs_pkg::OP_POKE && !cmd_reg.in_grid)
                            state_next = tcbs_pkg::ST_DONE;
                        else if (!row_valid_reg[p_sel])
                            state_next = tcbs_pkg::ST_FILL;
                        else
                            state_next = tcbs_pkg::ST_DONE;
                    end
                    tcbs_pkg::OP_NEWLINE:
                        state_next = row_valid_reg[p_sel] ? tcbs_pkg::ST_FILL
                                                          : tcbs_pkg::ST_LINE_END;
                    tcbs_pkg::OP_READ:
                        state_next = cmd_reg.in_grid ? tcbs_pkg::ST_READ : tcbs_pkg::ST_DONE;
                    default:
                        state_next = tcbs_pkg::ST_DONE;
                endcase
            end
            tcbs_pkg::ST_FILL:
            begin
                if (fill_col_reg == COL_LAST)
                begin
                    state_next = (cmd_reg.op == tcbs_pkg::OP_NEWLINE) ? tcbs_pkg::ST_LINE_END
                                                                      : tcbs_pkg::ST_START;
                end
            end
            tcbs_pkg::ST_LINE_END: state_next = tcbs_pkg::ST_DONE;
            tcbs_pkg::ST_READ:     state_next = tcbs_pkg::ST_DONE;
            tcbs_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = tcbs_pkg::ST_IDLE;
                end
            end
            default: state_next = tcbs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd_next       = cmd_reg;
        cur_row_next   = cur_row_reg;
        cur_col_next   = cur_col_reg;
        top_next       = top_reg;
        dirty_next     = dirty_reg;
        row_valid_next = row_valid_reg;
        row_sel_next   = row_sel_reg;
        fill_col_next  = fill_col_reg;
        cell_next      = cell_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        out_data_next  = out_data_reg;
        mem_we         = 1'b0;
        mem_waddr      = cell_addr(p_sel, col_sel);
        mem_wdata      = cmd_reg.ch;
        mem_re         = 1'b0;
        mem_raddr      = cell_addr(p_sel, col_sel);

        unique case (state_reg)
            tcbs_pkg::ST_IDLE:
            begin
                if (pop)
                begin
                    cmd_next = head;
                end
            end
            tcbs_pkg::ST_START:
            begin
                cell_next    = 8'h00;
                row_sel_next = p_sel;
                unique case (cmd_reg.op)
                    tcbs_pkg::OP_WRITE, tcbs_pkg::OP_POKE:
                    begin
                        if (cmd_reg.op == tcbs_pkg::OP_WRITE || cmd_reg.in_grid)
                        begin
                            if (!row_valid_reg[p_sel])
                            begin
                                fill_col_next = '0;
                            end
                            else
                            begin
                                mem_we = 1'b1;
                                if (cmd_reg.op == tcbs_pkg::OP_WRITE)
                                begin
                                    dirty_next = 1'b1;
                                    if (cur_col_reg == COL_LAST)
                                    begin
                                        cur_col_next = '0;
                                        cur_row_next = adv_row;
                                        top_next     = adv_top;
                                        if (scroll)
                                            row_valid_next[top_reg] = 1'b0;
                                    end
                                    else
                                    begin
                                        cur_col_next = cur_col_reg + CW'(1);
                                    end
                                end
                            end
                        end
                    end
                    tcbs_pkg::OP_NEWLINE:
                    begin
                        dirty_next    = 1'b1;
                        fill_col_next = cur_col_reg;
                    end
                    tcbs_pkg::OP_CLEAR:
                    begin
                        row_valid_next = '0;
                        cur_row_next   = '0;
                        cur_col_next   = '0;
                        top_next       = '0;
                        dirty_next     = 1'b1;
                    end
                    tcbs_pkg::OP_READ:
                        mem_re = cmd_reg.in_grid;
                    tcbs_pkg::OP_FLUSH:
                        dirty_next = 1'b0;
                    default:
                    begin
                    end
                endcase
            end
            tcbs_pkg::ST_FILL:
            begin
                mem_we        = 1'b1;
                mem_waddr     = cell_addr(row_sel_reg, fill_col_reg);
                mem_wdata     = tcbs_pkg::CHAR_SPACE;
                fill_col_next = fill_col_reg + CW'(1);
                if (fill_col_reg == COL_LAST)
                begin
                    row_valid_next[row_sel_reg] = 1'b1;
                end
            end
            tcbs_pkg::ST_LINE_END:
            begin
                cur_col_next = '0;
                cur_row_next = adv_row;
                top_next     = adv_top;
                if (scroll)
                    row_valid_next[top_reg] = 1'b0;
            end
            tcbs_pkg::ST_READ:
                cell_next = row_valid_reg[row_sel_reg] ? rd_data_reg : tcbs_pkg::CHAR_SPACE;
            tcbs_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {5'(cur_col_reg), 2'(cur_row_reg), dirty_reg, cell_reg};
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tcbs_pkg::ST_IDLE;
            cur_row_reg   <= '0;
            cur_col_reg   <= '0;
            top_reg       <= '0;
            dirty_reg     <= 1'b1;
            row_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cur_row_reg   <= cur_row_next;
            cur_col_reg   <= cur_col_next;
            top_reg       <= top_next;
            dirty_reg     <= dirty_next;
            row_valid_reg <= row_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        row_sel_reg  <= row_sel_next;
        fill_col_reg <= fill_col_next;
        cell_reg     <= cell_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

// ----- hw/rtl/text_console_buffer_scroll_core.sv -----
// Top level of the text console buffer with scroll.
//
// Input stream s_axis carries one command per transfer: tuser is the mode
// (write char, poke, clear, read, flush done), tdata the character, column
// and visible row. Output stream m_axis returns one result per command:
// read cell, dirty flag and cursor position after the command.
// Commands land in a four-entry queue; the grid engine executes them in
// order, one at a time, and holds the result in an output register.
// A write or poke into a row not yet touched first fills that row with spaces,
// and a newline in a used row fills the rest of that row with spaces (one
// space written per cycle) before the cursor moves on.
// Rows are tracked by per-row valid bits; a blank row reads as spaces, so
// reset and clear take effect at once with no sweep of the store.
// Reset empties the queue, homes the cursor and sets the dirty flag.
// If m_axis stalls, the engine parks on its finished result and the queue
// keeps taking commands until it fills, then s_axis_tready drops.
module text_console_buffer_scroll_core #(
    parameter int ROWS = tcbs_pkg::ROWS_DEF,
    parameter int COLS = tcbs_pkg::COLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // char_code[7:0], column[12:8], row[14:13]
    input  logic [2:0]  s_axis_tuser,  // mode[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // cell_char[7:0], is_dirty[8],
                                       // cursor_row_out[10:9], cursor_col_out[15:11]
);

    tcbs_pkg::q_status_t q_stat;
    tcbs_pkg::cmd_t      push_cmd;
    tcbs_pkg::cmd_t      head;
    logic                push;
    logic                pop;

    tcbs_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_stat        (q_stat),
        .push          (push),
        .push_cmd      (push_cmd)
    );

    tcbs_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_stat   (q_stat)
    );

    tcbs_engine #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ----- hw/rtl/tcbs_checker.sv -----
// Port-level checks for the text console buffer, bound to the top level.
module tcbs_checker #(
    parameter int ROWS = tcbs_pkg::ROWS_DEF,
    parameter int COLS = tcbs_pkg::COLS_DEF
) (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [15:0] s_axis_tdata,
    input logic [2:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    localparam int MAX_PEND = tcbs_pkg::QDEPTH + 2;
    localparam int PW       = $clog2(MAX_PEND + 2) + 1;

    logic [PW-1:0] pend_reg;
    logic          in_xfer, out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (in_xfer && !out_xfer)
        begin
            pend_reg <= pend_reg + PW'(1);
        end
        else if (out_xfer && !in_xfer)
        begin
            pend_reg <= pend_reg - PW'(1);
        end
    end

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && !s_axis_tready |=> s_axis_tvalid
                                            && $stable({s_axis_tuser, s_axis_tdata}))
        else $error("command changed while waiting");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer |-> pend_reg != '0)
        else $error("result without a pending command");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PW'(MAX_PEND))
        else $error("more commands in flight than storage allows");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (32'(m_axis_tdata[15:11]) < 32'(COLS))
                       && (32'(m_axis_tdata[10:9]) < 32'(ROWS)))
        else $error("cursor outside the grid");

endmodule

bind text_console_buffer_scroll_core tcbs_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tcbs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- bench/text_console_buffer_scroll_core_tb.sv -----
// Self-checking bench for the text console buffer core: directed table, then random traffic.
`timescale 1ns / 1ps

module text_console_buffer_scroll_core_tb;

    localparam int ROWS        = tcbs_pkg::ROWS_DEF;
    localparam int COLS        = tcbs_pkg::COLS_DEF;
    localparam int RANDOM_CMDS = 2000;
    localparam int QUIET_LIMIT = 4000;
    localparam int TAIL_CYCLES = 60;

    localparam logic [7:0] CHAR_SPACE   = tcbs_pkg::CHAR_SPACE;
    localparam logic [7:0] CHAR_NEWLINE = tcbs_pkg::CHAR_NEWLINE;

    localparam logic [2:0] MODE_WRITE = tcbs_pkg::MODE_WRITE;
    localparam logic [2:0] MODE_POKE  = tcbs_pkg::MODE_POKE;
    localparam logic [2:0] MODE_CLEAR = tcbs_pkg::MODE_CLEAR;
    localparam logic [2:0] MODE_READ  = tcbs_pkg::MODE_READ;
    localparam logic [2:0] MODE_FLUSH = tcbs_pkg::MODE_FLUSH;

    localparam logic [2:0] MODE_RSVD_A = 3'd5;
    localparam logic [2:0] MODE_RSVD_B = 3'd6;
    localparam logic [2:0] MODE_RSVD_C = 3'd7;

    typedef struct packed {
        logic [4:0] ccol;
        logic [1:0] crow;
        logic       dirty;
        logic [7:0] cchar;
    } cell_result_t;

    typedef struct packed {
        logic [2:0]   mode;
        logic [7:0]   ch;
        logic [4:0]   col;
        logic [1:0]   row;
        logic         typed;
        cell_result_t want;
    } step_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;

    text_console_buffer_scroll_core #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    always #4 clk = ~clk;

    // console model
    logic [7:0]   grid [ROWS*COLS];
    int           cur_row;
    int           cur_col;
    int           top_line;
    bit           dirty_q;
    cell_result_t pending_results [$];
    step_row_t    steps [$];
    int           errors = 0;
    bit           calm_tx = 1'b0;

    function automatic int cell_index(int vrow, int col);
        return ((top_line + vrow) % ROWS) * COLS + col;
    endfunction

    function automatic void console_reset();
        for (int k = 0; k < ROWS*COLS; k++) grid[k] = CHAR_SPACE;
        cur_row  = 0;
        cur_col  = 0;
        top_line = 0;
        dirty_q  = 1'b1;
    endfunction

    function automatic void put_and_advance(logic [7:0] c);
        int freed;
        grid[cell_index(cur_row, cur_col)] = c;
        cur_col++;
        if (cur_col >= COLS)
        begin
            cur_col = 0;
            cur_row++;
            if (cur_row >= ROWS)
            begin
                // oldest line is recycled as the blank bottom line
                freed    = top_line;
                top_line = (top_line + 1) % ROWS;
                for (int k = 0; k < COLS; k++) grid[freed*COLS + k] = CHAR_SPACE;
                cur_row = ROWS - 1;
            end
        end
    endfunction

    function automatic cell_result_t console_apply(logic [2:0] mode, logic [7:0] ch,
                                                   logic [4:0] col, logic [1:0] row);
        cell_result_t r;
        bit           on_grid;
        int           span;
        r       = '0;
        on_grid = (row < ROWS) && (col < COLS);
        case (mode)
            MODE_WRITE:
            begin
                dirty_q = 1'b1;
                if (ch == CHAR_NEWLINE)
                begin
                    span = COLS - cur_col;
                    for (int k = 0; k < span; k++) put_and_advance(CHAR_SPACE);
                end
                else
                begin
                    put_and_advance(ch);
                end
            end
            MODE_POKE: if (on_grid) grid[cell_index(row, col)] = ch;
            MODE_CLEAR: console_reset();
            MODE_READ: if (on_grid) r.cchar = grid[cell_index(row, col)];
            MODE_FLUSH: dirty_q = 1'b0;
            default: ;
        endcase
        r.dirty = dirty_q;
        r.crow  = cur_row[1:0];
        r.ccol  = cur_col[4:0];
        return r;
    endfunction

    function automatic cell_result_t res(logic [7:0] cchar, logic dirty, logic [1:0] crow,
                                         logic [4:0] ccol);
        cell_result_t r;
        r.cchar = cchar;
        r.dirty = dirty;
        r.crow  = crow;
        r.ccol  = ccol;
        return r;
    endfunction

    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic send_cmd(logic [2:0] mode, logic [7:0] ch, logic [4:0] col,
                            logic [1:0] row, logic typed, cell_result_t want, int gap);
        cell_result_t predicted;
        repeat (gap)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {1'b0, row, col, ch};
        do @(posedge clk); while (!s_axis_tready);
        predicted = console_apply(mode, ch, col, row);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    // result checker
    cell_result_t got;
    cell_result_t want_r;
    bit           bad;

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (pending_results.size() == 0)
            begin
                $display("%0t: result expected none got %h", $time, got);
                errors++;
            end
            else
            begin
                want_r = pending_results.pop_front();
                bad    = 1'b0;
                if (got.cchar !== want_r.cchar)
                begin
                    $display("%0t: cell_char expected %h got %h", $time,
                             want_r.cchar, got.cchar);
                    bad = 1'b1;
                end
                if (got.dirty !== want_r.dirty)
                begin
                    $display("%0t: is_dirty expected %b got %b", $time, want_r.dirty, got.dirty);
                    bad = 1'b1;
                end
                if (got.crow !== want_r.crow)
                begin
                    $display("%0t: cursor_row_out expected %0d got %0d", $time,
                             want_r.crow, got.crow);
                    bad = 1'b1;
                end
                if (got.ccol !== want_r.ccol)
                begin
                    $display("%0t: cursor_col_out expected %0d got %0d", $time,
                             want_r.ccol, got.ccol);
                    bad = 1'b1;
                end
                if (bad) errors++;
            end
        end
    end

    // result side backpressure
    initial
    begin
        int  stall;
        int  burst;
        bit  calm_rx;
        calm_rx = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 19) == 0) calm_rx = ($urandom_range(0, 2) == 0);
            stall = pick_gap(calm_rx);
            repeat (stall)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
            end
            burst = $urandom_range(1, 8);
            repeat (burst)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog: cycles without any transfer
    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        logic [2:0] mode;
        logic [7:0] ch;
        logic [4:0] col;
        logic [1:0] row;
        int         pick;

        console_reset();
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        steps.push_back('{MODE_READ,   8'h00,        5'd0,  2'd0, 1'b1,
                          res(8'h20, 1'b1, 2'd0, 5'd0)});
        steps.push_back('{MODE_READ,   8'h00,        5'd20, 2'd3, 1'b1,
                          res(8'h20, 1'b1, 2'd0, 5'd0)});
        steps.push_back('{MODE_READ,   8'hFF,        5'd31, 2'd3, 1'b1,
                          res(8'h00, 1'b1, 2'd0, 5'd0)});
        steps.push_back('{MODE_FLUSH,  8'h00,        5'd0,  2'd0, 1'b1,
                          res(8'h00, 1'b0, 2'd0, 5'd0)});
        steps.push_back('{MODE_POKE,   8'hFF,        5'd20, 2'd3, 1'b1,
                          res(8'h00, 1'b0, 2'd0, 5'd0)});
        steps.push_back('{MODE_READ,   8'h00,        5'd20, 2'd3, 1'b1,
                          res(8'hFF, 1'b0, 2'd0, 5'd0)});
        steps.push_back('{MODE_POKE,   8'h41,        5'd21, 2'd0, 1'b1,
                          res(8'h00, 1'b0, 2'd0, 5'd0)});
        steps.push_back('{MODE_READ,   8'h00,        5'd21, 2'd0, 1'b1,
                          res(8'h00, 1'b0, 2'd0, 5'd0)});
        steps.push_back('{MODE_WRITE,  8'h00,        5'd0,  2'd0, 1'b1,
                          res(8'h00, 1'b1, 2'd0, 5'd1)});
        steps.push_back('{MODE_WRITE,  8'hFF,        5'd0,  2'd0, 1'b1,
                          res(8'h00, 1'b1, 2'd0, 5'd2)});
        steps.push_back('{MODE_WRITE,  CHAR_NEWLINE, 5'd0,  2'd0, 1'b1,
                          res(8'h00, 1'b1, 2'd1, 5'd0)});
        steps.push_back('{MODE_READ,   8'h00,        5'd1,  2'd0, 1'b1,
                          res(8'hFF, 1'b1, 2'd1, 5'd0)});
        steps.push_back('{MODE_RSVD_A, 8'hFF,        5'd31, 2'd3, 1'b1,
                          res(8'h00, 1'b1, 2'd1, 5'd0)});
        steps.push_back('{MODE_RSVD_B, 8'h00,        5'd0,  2'd0, 1'b0, '0});
        steps.push_back('{MODE_RSVD_C, 8'hFF,        5'd1,  2'd0, 1'b0, '0});
        steps.push_back('{MODE_WRITE,  CHAR_NEWLINE, 5'd0,  2'd0, 1'b0, '0});
        steps.push_back('{MODE_WRITE,  CHAR_NEWLINE, 5'd0,  2'd0, 1'b0, '0});
        steps.push_back('{MODE_WRITE,  CHAR_NEWLINE, 5'd0,  2'd0, 1'b0, '0});
        steps.push_back('{MODE_READ,   8'h00,        5'd20, 2'd3, 1'b0, '0});
        steps.push_back('{MODE_READ,   8'h00,        5'd1,  2'd0, 1'b0, '0});
        steps.push_back('{MODE_WRITE,  8'h55,        5'd0,  2'd0, 1'b0, '0});
        steps.push_back('{MODE_WRITE,  8'hAA,        5'd0,  2'd0, 1'b0, '0});
        steps.push_back('{MODE_WRITE,  CHAR_NEWLINE, 5'd0,  2'd0, 1'b0, '0});
        steps.push_back('{MODE_CLEAR,  8'h00,        5'd0,  2'd0, 1'b1,
                          res(8'h00, 1'b1, 2'd0, 5'd0)});
        steps.push_back('{MODE_READ,   8'h00,        5'd20, 2'd3, 1'b1,
                          res(8'h20, 1'b1, 2'd0, 5'd0)});
        steps.push_back('{MODE_WRITE,  CHAR_NEWLINE, 5'd0,  2'd0, 1'b1,
                          res(8'h00, 1'b1, 2'd1, 5'd0)});

        foreach (steps[i])
            send_cmd(steps[i].mode, steps[i].ch, steps[i].col, steps[i].row,
                     steps[i].typed, steps[i].want, pick_gap(1'b0));
        drain_results();

        for (int n = 0; n < RANDOM_CMDS; n++)
        begin
            if (n % 250 == 0) calm_tx = ($urandom_range(0, 3) == 0);
            if (n == RANDOM_CMDS / 2 || $urandom_range(0, 299) == 0) drain_results();
            pick = $urandom_range(0, 99);
            ch   = 8'($urandom);
            row  = 2'($urandom_range(0, 3));
            col  = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(21, 31))
                                               : 5'($urandom_range(0, 20));
            if (pick < 45)
            begin
                mode = MODE_WRITE;
            end
            else if (pick < 53)
            begin
                mode = MODE_WRITE;
                ch   = CHAR_NEWLINE;
            end
            else if (pick < 65)
            begin
                mode = MODE_POKE;
            end
            else if (pick < 83)
            begin
                mode = MODE_READ;
            end
            else if (pick < 85)
            begin
                mode = MODE_CLEAR;
            end
            else if (pick < 93)
            begin
                mode = MODE_FLUSH;
            end
            else if (pick < 95)
            begin
                mode = MODE_RSVD_A;
            end
            else if (pick < 97)
            begin
                mode = MODE_RSVD_B;
            end
            else
            begin
                mode = MODE_RSVD_C;
            end
            send_cmd(mode, ch, col, row, 1'b0, '0, pick_gap(calm_tx));
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
